// ===== rtl/core/slfd_pkg.sv =====
// slfd_pkg: shared types and constants of the fixed length slip deframer
// depends on nothing; imported by every module under rtl/core
package slfd_pkg;

    // slip special bytes
    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    // payload length after reset
    localparam logic [7:0] PACKET_SIZE_RESET = 8'd16;

    // frame phase, one-hot
    typedef enum logic [2:0] {
        PH_OPEN  = 3'b001,
        PH_DATA  = 3'b010,
        PH_CLOSE = 3'b100
    } phase_t;

    // one decoded result word between decoder and output register
    typedef struct packed {
        logic       emit;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       bad_escape;
    } result_t;

endpackage

// ===== rtl/core/slfd_in_reg.sv =====
// slfd_in_reg: input register stage holding one received word
// depends on slfd_pkg (no items used beyond the import convention)
module slfd_in_reg
    import slfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       out_free,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // stage frees up when empty or when its word moves on this cycle
    assign s_ready    = !valid_reg || out_free;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, loaded on accept
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

// ===== rtl/core/slfd_decoder.sv =====
// slfd_decoder: frame phase, escape and byte count state plus per-word decode
// depends on slfd_pkg for slip codes, phase_t and result_t
module slfd_decoder
    import slfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       out_free,
    output result_t    result
);

    phase_t     phase_reg, phase_next;
    logic       esc_reg, esc_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] size_reg;
    logic [7:0] count_inc;
    logic       consume;

    assign consume   = item_valid && out_free;
    assign count_inc = count_reg + 8'd1;

    // packet size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= PACKET_SIZE_RESET;
        end else if (cfg_we) begin
            size_reg <= cfg_wdata;
        end
    end

    // decode of the current word
    always_comb begin
        phase_next        = phase_reg;
        esc_next          = esc_reg;
        count_next        = count_reg;
        result.emit       = 1'b0;
        result.data_byte  = item_byte;
        result.last_byte  = 1'b0;
        result.bad_escape = 1'b0;
        unique case (phase_reg)
            PH_DATA: begin
                if (esc_reg) begin
                    esc_next    = 1'b0;
                    result.emit = 1'b1;
                    if (item_byte == SLIP_ESC_END) begin
                        result.data_byte = SLIP_END;
                    end else if (item_byte == SLIP_ESC_ESC) begin
                        result.data_byte = SLIP_ESC;
                    end else begin
                        result.bad_escape = 1'b1;
                    end
                end else if (item_byte == SLIP_ESC) begin
                    esc_next = 1'b1;
                end else begin
                    result.emit = 1'b1;
                end
                if (result.emit) begin
                    count_next = count_inc;
                    if (count_inc == size_reg) begin
                        result.last_byte = 1'b1;
                        phase_next       = PH_CLOSE;
                    end
                end
            end
            PH_CLOSE: begin
                phase_next = PH_OPEN;
            end
            default: begin
                // opening delimiter, dropped unchecked
                phase_next = PH_DATA;
                esc_next   = 1'b0;
                count_next = 8'd0;
            end
        endcase
    end

    // state advances only when the word is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPEN;
            esc_reg   <= 1'b0;
            count_reg <= 8'd0;
        end else if (consume) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/slfd_out_reg.sv =====
// slfd_out_reg: result register driving the output channel
// depends on slfd_pkg for result_t
module slfd_out_reg
    import slfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    input  result_t    result,
    output logic       out_free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_last_byte,
    output logic       m_bad_escape
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       bad_reg;

    // slot is free when empty or its word is taken this cycle
    assign out_free   = !valid_reg || m_ready;
    assign valid_next = out_free ? (item_valid && result.emit) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, loaded with each new result word
    always_ff @(posedge aclk) begin
        if (out_free && item_valid && result.emit) begin
            data_reg <= result.data_byte;
            last_reg <= result.last_byte;
            bad_reg  <= result.bad_escape;
        end
    end

    assign m_valid      = valid_reg;
    assign m_data_byte  = data_reg;
    assign m_last_byte  = last_reg;
    assign m_bad_escape = bad_reg;

endmodule

// ===== rtl/core/slip_fixed_length_deframer.sv =====
// slip_fixed_length_deframer: top level of the fixed length slip deframer
// depends on slfd_pkg, slfd_in_reg, slfd_decoder, slfd_out_reg
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------
//  input    | s_valid/s_ready  | s_rx_byte
//  result   | m_valid/m_ready  | m_data_byte, m_last_byte, m_bad_escape
//  config   | cfg_we           | cfg_wdata (packet_size)
//
// one word is taken every cycle while the result register is free; a result
// reaches the result register through the input register, then decode into it
// words that give no result (delimiters, escape bytes) just leave the pipe
// reset is synchronous and active low; no clearing pass
// a stall on m_ready holds the result register and backs up into s_ready
module slip_fixed_length_deframer
    import slfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_last_byte,
    output logic       m_bad_escape
);

    logic       out_free;
    logic       item_valid;
    logic [7:0] item_byte;
    result_t    result;

    // input register
    slfd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .out_free   (out_free),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    // decode and frame state
    slfd_decoder u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .out_free   (out_free),
        .result     (result)
    );

    // result register
    slfd_out_reg u_out_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .result       (result),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_byte  (m_data_byte),
        .m_last_byte  (m_last_byte),
        .m_bad_escape (m_bad_escape)
    );

endmodule

// ===== tb/sv/slip_fixed_length_deframer_test.sv =====
// slip_fixed_length_deframer_test: self-checking bench for the fixed length slip deframer
// drives framed byte streams under several packet sizes and checks every decoded word
// depends on slfd_pkg and slip_fixed_length_deframer
module slip_fixed_length_deframer_test;
    import slfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PIPE_SETTLE    = 4;

    // expected decoded word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       bad_escape;
    } decoded_byte_t;

    // frame decoder model plus queue of decoded words still owed by the block
    class slip_frame_scoreboard;
        logic [7:0]    packet_size;
        phase_t        phase;
        bit            esc_pending;
        logic [7:0]    bytes_done;
        decoded_byte_t decoded_q[$];
        int            errors;

        function new();
            packet_size = PACKET_SIZE_RESET;
            phase       = PH_OPEN;
            esc_pending = 1'b0;
            bytes_done  = 8'd0;
            errors      = 0;
        endfunction

        // one raw byte accepted on the input channel
        function void note_rx_byte(logic [7:0] b);
            decoded_byte_t d;
            case (phase)
                PH_DATA: begin
                    d.bad_escape = 1'b0;
                    if (esc_pending) begin
                        esc_pending = 1'b0;
                        if (b == SLIP_ESC_END) begin
                            d.data_byte = SLIP_END;
                        end else if (b == SLIP_ESC_ESC) begin
                            d.data_byte = SLIP_ESC;
                        end else begin
                            // bad escape: byte goes out as is, never starts a new escape
                            d.data_byte  = b;
                            d.bad_escape = 1'b1;
                        end
                    end else if (b == SLIP_ESC) begin
                        esc_pending = 1'b1;
                        return;
                    end else begin
                        d.data_byte = b;
                    end
                    // 8-bit count, compared against the live packet size
                    bytes_done  = bytes_done + 8'd1;
                    d.last_byte = (bytes_done == packet_size);
                    if (d.last_byte)
                        phase = PH_CLOSE;
                    decoded_q.push_back(d);
                end
                PH_CLOSE: begin
                    phase = PH_OPEN;
                end
                default: begin
                    // opening delimiter, dropped unchecked
                    phase       = PH_DATA;
                    esc_pending = 1'b0;
                    bytes_done  = 8'd0;
                end
            endcase
        endfunction

        // one word accepted on the result channel
        function void check_result(logic [7:0] data_byte, logic last_byte, logic bad_escape);
            decoded_byte_t d;
            if (decoded_q.size() == 0) begin
                $error("unexpected word: data_byte %h last_byte %b bad_escape %b",
                       data_byte, last_byte, bad_escape);
                errors++;
                return;
            end
            d = decoded_q.pop_front();
            if (data_byte !== d.data_byte) begin
                $error("data_byte: expected %h, actual %h", d.data_byte, data_byte);
                errors++;
            end
            if (last_byte !== d.last_byte) begin
                $error("last_byte: expected %b, actual %b", d.last_byte, last_byte);
                errors++;
            end
            if (bad_escape !== d.bad_escape) begin
                $error("bad_escape: expected %b, actual %b", d.bad_escape, bad_escape);
                errors++;
            end
        endfunction
    endclass

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       cfg_we       = 1'b0;
    logic [7:0] cfg_wdata    = 8'd0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte    = 8'd0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [7:0] m_data_byte;
    logic       m_last_byte;
    logic       m_bad_escape;

    slip_frame_scoreboard sb = new();

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         rx_count      = 0;
    int         idle_cycles   = 0;
    logic [7:0] cur_size      = PACKET_SIZE_RESET;

    slip_fixed_length_deframer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_byte  (m_data_byte),
        .m_last_byte  (m_last_byte),
        .m_bad_escape (m_bad_escape)
    );

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data_byte, m_last_byte, m_bad_escape);
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // push one raw byte, with random gaps in front of it
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_rx_byte(b);
        rx_count++;
    endtask

    // stop sending and let every owed word and any dropped byte leave the pipe
    task automatic drain;
        s_valid <= 1'b0;
        while (sb.decoded_q.size() != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_packet_size(input logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we         <= 1'b0;
        sb.packet_size  = v;
        cur_size        = v;
    endtask

    // one frame of the current size with random content; sometimes cut short or
    // followed by stray bytes; stops mid-frame once the phase budget is used
    task automatic send_frame(input int budget_end);
        int         n;
        int         kind;
        logic [7:0] b;
        n = (cur_size == 8'd0) ? 256 : cur_size;
        if ($urandom_range(99) < 5)
            n = $urandom_range(n - 1, 0);
        send_byte(($urandom_range(99) < 85) ? SLIP_END : 8'($urandom));
        for (int i = 0; i < n; i++) begin
            if (rx_count >= budget_end)
                return;
            kind = $urandom_range(99);
            if (kind < 50) begin
                do b = 8'($urandom); while (b == SLIP_ESC);
                send_byte(b);
            end else if (kind < 60) begin
                send_byte(SLIP_END);
            end else if (kind < 70) begin
                send_byte(SLIP_ESC);
                send_byte(SLIP_ESC_END);
            end else if (kind < 80) begin
                send_byte(SLIP_ESC);
                send_byte(SLIP_ESC_ESC);
            end else if (kind < 86) begin
                do b = 8'($urandom); while (b == SLIP_ESC_END || b == SLIP_ESC_ESC);
                send_byte(SLIP_ESC);
                send_byte(b);
            end else begin
                send_byte(($urandom_range(1) == 0) ? 8'h00 : 8'hFF);
            end
        end
        send_byte(($urandom_range(99) < 85) ? SLIP_END : 8'($urandom));
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
        end
    endtask

    // directed frame at the reset packet size of 16
    logic [7:0] directed_bytes[$] = '{
        SLIP_END,
        8'h00, 8'hFF,
        SLIP_ESC, SLIP_ESC_END,
        SLIP_ESC, SLIP_ESC_ESC,
        SLIP_ESC, 8'h41,
        SLIP_ESC, SLIP_ESC,
        SLIP_END,
        SLIP_ESC, SLIP_END,
        8'h7F, 8'h80, SLIP_ESC_END, SLIP_ESC_ESC, 8'h55, 8'hAA, 8'h01, 8'h02,
        SLIP_END,
        SLIP_ESC
    };

    // phase plan: packet size, byte budget, sender and receiver idle percent
    int         phase_items[6] = '{120, 280, 120, 280, 100, 100};
    logic [7:0] phase_sizes[6];
    int         phase_send[6]  = '{18, 18, 55, 55, 0, 0};
    int         phase_recv[6]  = '{55, 55, 18, 18, 0, 0};

    initial begin
        int budget_end;
        phase_sizes = '{8'd1, 8'd255, 8'd5, 8'd0, 8'd3, 8'($urandom_range(40, 2))};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = phase_send[0];
        recv_idle_pct = phase_recv[0];
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        for (int p = 0; p < 6; p++) begin
            write_packet_size(phase_sizes[p]);
            send_idle_pct = phase_send[p];
            recv_idle_pct = phase_recv[p];
            budget_end    = rx_count + phase_items[p];
            while (rx_count < budget_end)
                send_frame(budget_end);
        end

        drain();
        if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
